// ===== rtl/shrm_pkg.sv =====
// ----------------------------------------------------------------------------
// shrm_pkg
// Shared types and constants for the sample-and-hold range mapper.
// ----------------------------------------------------------------------------
package shrm_pkg;

	// Millivolt fields on the input stream
	localparam int MV_W      = 15;
	localparam int BOUND_W   = 16;
	localparam int IN_W      = 112;
	localparam int OUT_W     = 24;
	localparam int OUT_MV_W  = 16;

	// Input tdata layout, lowest bit first
	localparam int F_SIG_LSB    = 0;
	localparam int F_MIN_LSB    = 15;
	localparam int F_MAX_LSB    = 30;
	localparam int F_START_LSB  = 45;
	localparam int F_END_LSB    = 60;
	localparam int F_TOG_LSB    = 75;
	localparam int F_GATE_LSB   = 90;
	localparam int F_SIG_PRES   = 105;
	localparam int F_TOG_PRES   = 106;
	localparam int F_GATE_PRES  = 107;
	localparam int F_BUTTON     = 108;

	// Schmitt trigger thresholds, mV
	localparam logic signed [MV_W-1:0] LOW_MV  = 15'sd100;
	localparam logic signed [MV_W-1:0] HIGH_MV = 15'sd2000;

	// Bound scaling: divide by 10000 via reciprocal floor(2^42 / 10000)
	localparam int          CV_UNITY    = 10000;
	localparam int          RECIP_SHIFT = 42;
	localparam logic [28:0] RECIP_M     = 29'd439804651;

	// Sequential divider
	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// APB register map (word index)
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_MIN_KNOB   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_KNOB   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_START_KNOB = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_END_KNOB   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INIT_HOLD  = 3'd4;

	// Knobs in order min, max, start, end
	typedef logic [3:0][MV_W-1:0] knob_arr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BMUL,
		ST_BREC,
		ST_BCHK,
		ST_BFIX,
		ST_MMUL,
		ST_DSTART,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_LOAD,
		STEP_BMUL,
		STEP_BREC,
		STEP_BCHK,
		STEP_BFIX,
		STEP_MMUL,
		STEP_DSTART,
		STEP_FIN
	} dp_step_t;

	typedef struct packed {
		dp_step_t   step;
		logic [1:0] bidx;
	} dp_cmd_t;

	typedef struct packed {
		logic sig_present;
		logic tog_present;
		logic gate_present;
		logic button;
		logic tog_ge_high;
		logic tog_le_low;
		logic gate_ge_high;
		logic gate_le_low;
		logic div_done;
	} dp_status_t;

	typedef struct packed {
		logic ready;
		logic done;
		logic updated;
		logic hold;
	} ctrl_status_t;

endpackage

// ===== rtl/shrm_div.sv =====
// ----------------------------------------------------------------------------
// shrm_div
// Unsigned restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module shrm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [shrm_pkg::DIV_NUM_W-1:0] num,
	input  logic [shrm_pkg::DIV_DEN_W-1:0] den,
	output logic                          done,
	output logic [shrm_pkg::DIV_NUM_W-1:0] quot
);
	import shrm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] nq_q;   // numerator shifts out, quotient shifts in
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, nq_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			nq_q  <= {nq_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

// ===== rtl/shrm_dp.sv =====
// ----------------------------------------------------------------------------
// shrm_dp
// Datapath: scaled bounds, linear map, quotient sign, saturation, held value.
// ----------------------------------------------------------------------------
module shrm_dp #(
	parameter int VOLT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  shrm_pkg::dp_cmd_t              cmd,
	input  logic [shrm_pkg::IN_W-1:0]      in_data,
	input  shrm_pkg::knob_arr_t            knobs,
	output shrm_pkg::dp_status_t           status,
	output logic [shrm_pkg::OUT_MV_W-1:0]  out_mv
);
	import shrm_pkg::*;

	localparam int SUM_W = 34;
	localparam int EXT_W = (VOLT_BITS > OUT_MV_W) ? VOLT_BITS : OUT_MV_W;
	localparam longint SAT_HI_L = (longint'(1) << (VOLT_BITS - 1)) - 1;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAT_HI_L);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-SAT_HI_L - 1);

	// Input fields
	logic signed [MV_W-1:0] in_tog;
	logic signed [MV_W-1:0] in_gate;

	// Captured sample
	logic signed [MV_W-1:0]  sig_q;
	logic [3:0][MV_W-1:0]    cv_q;

	// Bound pipeline registers
	logic signed [61:0]      prod_q;
	logic [28:0]             mag_q;
	logic                    neg_q;
	logic [14:0]             q0_q;
	logic [3:0][BOUND_W-1:0] bound_q;

	// Map registers
	logic [DIV_DEN_W-1:0]    den_mag_q;
	logic                    den_neg_q;
	logic                    den_zero_q;
	logic                    q_neg_q;
	logic signed [VOLT_BITS-1:0] held_q;

	// Shared multiplier
	logic signed [30:0]      mul_a;
	logic signed [30:0]      mul_b;
	logic signed [61:0]      mul_p;

	logic signed [MV_W-1:0]  cv_sel;
	logic [BOUND_W-1:0]      cv_ext;
	logic [BOUND_W-1:0]      cv_abs;
	logic [29:0]             p_neg;
	logic [28:0]             mag;
	logic [14:0]             q0;
	logic [28:0]             rem;
	logic [BOUND_W-1:0]      q_fix;
	logic signed [BOUND_W-1:0] b_lo, b_hi, b_st, b_en;
	logic signed [16:0]      dif_sig;
	logic signed [16:0]      dif_out;
	logic signed [16:0]      dif_den;
	logic [16:0]             den_neg_v;
	logic [32:0]             num_neg_v;
	logic [DIV_NUM_W-1:0]    num_mag;
	logic                    div_start;
	logic                    div_done;
	logic [DIV_NUM_W-1:0]    div_quot;
	logic signed [SUM_W-1:0] q_signed;
	logic signed [SUM_W-1:0] map_sum;
	logic signed [SUM_W-1:0] map_sat;
	logic signed [EXT_W-1:0] held_ext;

	assign in_tog  = in_data[F_TOG_LSB +: MV_W];
	assign in_gate = in_data[F_GATE_LSB +: MV_W];

	// Trigger levels and jack flags for the controller
	assign status.sig_present  = in_data[F_SIG_PRES];
	assign status.tog_present  = in_data[F_TOG_PRES];
	assign status.gate_present = in_data[F_GATE_PRES];
	assign status.button       = in_data[F_BUTTON];
	assign status.tog_ge_high  = in_tog >= HIGH_MV;
	assign status.tog_le_low   = in_tog <= LOW_MV;
	assign status.gate_ge_high = in_gate >= HIGH_MV;
	assign status.gate_le_low  = in_gate <= LOW_MV;
	assign status.div_done     = div_done;

	// Bound step helpers
	assign cv_sel = cv_q[cmd.bidx];
	assign cv_ext = {cv_sel[MV_W-1], cv_sel};
	assign cv_abs = cv_sel[MV_W-1] ? (BOUND_W'(0) - cv_ext) : cv_ext;
	assign p_neg  = 30'd0 - prod_q[29:0];
	assign mag    = prod_q[29] ? p_neg[28:0] : prod_q[28:0];
	assign q0     = prod_q[RECIP_SHIFT +: 15];
	assign rem    = mag_q - prod_q[28:0];
	assign q_fix  = {1'b0, q0_q} + BOUND_W'(rem >= 29'(CV_UNITY));

	// Map step helpers
	assign b_lo    = bound_q[0];
	assign b_hi    = bound_q[1];
	assign b_st    = bound_q[2];
	assign b_en    = bound_q[3];
	assign dif_sig = {{2{sig_q[MV_W-1]}}, sig_q} - {b_lo[BOUND_W-1], b_lo};
	assign dif_out = {b_en[BOUND_W-1], b_en} - {b_st[BOUND_W-1], b_st};
	assign dif_den = {b_hi[BOUND_W-1], b_hi} - {b_lo[BOUND_W-1], b_lo};
	assign den_neg_v = 17'd0 - dif_den;
	assign num_neg_v = 33'd0 - prod_q[32:0];
	assign num_mag   = prod_q[32] ? num_neg_v[DIV_NUM_W-1:0] : prod_q[DIV_NUM_W-1:0];

	// Multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			STEP_BMUL: begin
				mul_a = 31'(signed'(knobs[cmd.bidx]));
				mul_b = {15'd0, cv_abs};
			end
			STEP_BREC: begin
				mul_a = {2'b00, mag};
				mul_b = {2'b00, RECIP_M};
			end
			STEP_BCHK: begin
				mul_a = {16'd0, q0};
				mul_b = 31'(CV_UNITY);
			end
			STEP_MMUL: begin
				mul_a = 31'(dif_sig);
				mul_b = 31'(dif_out);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Final value: sign the quotient, add start, saturate
	assign q_signed = q_neg_q ? (SUM_W'(0) - SUM_W'(div_quot)) : SUM_W'(div_quot);
	assign map_sum  = SUM_W'(b_st) + q_signed;
	always_comb begin
		if (map_sum > SAT_HI) begin
			map_sat = SAT_HI;
		end else if (map_sum < SAT_LO) begin
			map_sat = SAT_LO;
		end else begin
			map_sat = map_sum;
		end
	end

	assign div_start = cmd.step == STEP_DSTART;

	// Working registers
	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_LOAD: begin
				sig_q   <= in_data[F_SIG_LSB +: MV_W];
				cv_q[0] <= in_data[F_MIN_LSB +: MV_W];
				cv_q[1] <= in_data[F_MAX_LSB +: MV_W];
				cv_q[2] <= in_data[F_START_LSB +: MV_W];
				cv_q[3] <= in_data[F_END_LSB +: MV_W];
			end
			STEP_BMUL: begin
				prod_q <= mul_p;
			end
			STEP_BREC: begin
				prod_q <= mul_p;
				mag_q  <= mag;
				neg_q  <= prod_q[29];
			end
			STEP_BCHK: begin
				prod_q <= mul_p;
				q0_q   <= q0;
			end
			STEP_BFIX: begin
				bound_q[cmd.bidx] <= neg_q ? (BOUND_W'(0) - q_fix) : q_fix;
			end
			STEP_MMUL: begin
				prod_q     <= mul_p;
				den_mag_q  <= dif_den[16] ? den_neg_v[DIV_DEN_W-1:0]
				                          : dif_den[DIV_DEN_W-1:0];
				den_neg_q  <= dif_den[16];
				den_zero_q <= dif_den == 17'sd0;
			end
			STEP_DSTART: begin
				q_neg_q <= prod_q[32] ^ den_neg_q;
			end
			default: begin
			end
		endcase
	end

	// Held output value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.step == STEP_FIN) begin
			held_q <= den_zero_q ? '0 : VOLT_BITS'(map_sat);
		end
	end

	assign held_ext = EXT_W'(held_q);
	assign out_mv   = held_ext[OUT_MV_W-1:0];

	shrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_mag),
		.den    (den_mag_q),
		.done   (div_done),
		.quot   (div_quot)
	);

endmodule

// ===== rtl/shrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// shrm_ctrl
// Controller: trigger and hold state, refresh decision, step sequencing.
// ----------------------------------------------------------------------------
module shrm_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     out_free,
	input  logic                     cfg_hold_we,
	input  logic                     cfg_hold_val,
	input  shrm_pkg::dp_status_t     dp_st,
	output shrm_pkg::dp_cmd_t        cmd,
	output shrm_pkg::ctrl_status_t   st
);
	import shrm_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        hold_q, hold_d;
	logic        tog_hi_q, tog_hi_d;
	logic        gate_hi_q, gate_hi_d;
	logic        upd_q, upd_d;
	logic [1:0]  bidx_q, bidx_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Trigger, hold and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= 1'b0;
			tog_hi_q  <= 1'b1;
			gate_hi_q <= 1'b1;
			upd_q     <= 1'b0;
			bidx_q    <= '0;
		end else begin
			hold_q    <= cfg_hold_we ? cfg_hold_val : hold_d;
			tog_hi_q  <= tog_hi_d;
			gate_hi_q <= gate_hi_d;
			upd_q     <= upd_d;
			bidx_q    <= bidx_d;
		end
	end

	// Next state and commands
	always_comb begin
		logic tog_rise;
		logic gate_rise;
		logic refresh;

		state_d    = state_q;
		hold_d     = hold_q;
		tog_hi_d   = tog_hi_q;
		gate_hi_d  = gate_hi_q;
		upd_d      = upd_q;
		bidx_d     = bidx_q;
		cmd.step   = STEP_IDLE;
		cmd.bidx   = bidx_q;
		st.ready   = 1'b0;
		st.done    = 1'b0;
		st.updated = upd_q;
		st.hold    = hold_q;
		tog_rise   = 1'b0;
		gate_rise  = 1'b0;
		refresh    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				st.ready = 1'b1;
				if (in_valid) begin
					cmd.step = STEP_LOAD;
					// toggle trigger: a rising edge flips hold mode
					if (dp_st.tog_present) begin
						if (tog_hi_q) begin
							if (dp_st.tog_le_low) begin
								tog_hi_d = 1'b0;
							end
						end else if (dp_st.tog_ge_high) begin
							tog_hi_d = 1'b1;
							tog_rise = 1'b1;
						end
					end
					hold_d = hold_q ^ tog_rise;
					// refresh decision; gate trigger only in hold mode w/o button
					if (dp_st.sig_present) begin
						if (hold_d) begin
							if (dp_st.button) begin
								refresh = 1'b1;
							end else if (dp_st.gate_present) begin
								if (gate_hi_q) begin
									if (dp_st.gate_le_low) begin
										gate_hi_d = 1'b0;
									end
								end else if (dp_st.gate_ge_high) begin
									gate_hi_d = 1'b1;
									gate_rise = 1'b1;
								end
								refresh = gate_rise;
							end
						end else begin
							refresh = 1'b1;
						end
					end
					upd_d   = refresh;
					bidx_d  = '0;
					state_d = refresh ? ST_BMUL : ST_DONE;
				end
			end
			ST_BMUL: begin
				cmd.step = STEP_BMUL;
				state_d  = ST_BREC;
			end
			ST_BREC: begin
				cmd.step = STEP_BREC;
				state_d  = ST_BCHK;
			end
			ST_BCHK: begin
				cmd.step = STEP_BCHK;
				state_d  = ST_BFIX;
			end
			ST_BFIX: begin
				cmd.step = STEP_BFIX;
				bidx_d   = bidx_q + 1'b1;
				state_d  = (bidx_q == 2'd3) ? ST_MMUL : ST_BMUL;
			end
			ST_MMUL: begin
				cmd.step = STEP_MMUL;
				state_d  = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.step = STEP_DSTART;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				if (dp_st.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.step = STEP_FIN;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					st.done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sample_hold_range_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// sample_hold_range_mapper_unit
// Sample-and-hold with linear rescale of a millivolt signal into a
// CV-scaled output range, with toggle and gate Schmitt triggers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// config    in         psel/penable/pready    5 registers, 32-bit, paddr[4:2]
// s_*       in         s_tvalid/s_tready      one tick: signal, CVs, jack flags
// m_*       out        m_tvalid/m_tready      out_mv, updated, hold_active
//
// A refreshing tick runs through four scaled bounds, each as multiply, reciprocal,
// check and fix steps on the shared multiplier, then map product, divider start,
// the divider shifts and its done strobe, final sum and hand-off. A tick without
// refresh goes straight from acceptance to hand-off.
// One tick is in work at a time; the next is taken once the result has moved
// into the output register, which may still be waiting on m_tready.
// Reset sets both triggers high and clears hold mode and held value; no clearing pass.
//
module sample_hold_range_mapper_unit #(
	parameter int VOLT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// signal_mv, min_cv_mv, max_cv_mv, start_cv_mv, end_cv_mv, toggle_cv_mv,
	// gate_cv_mv (15 bits each), signal_present, toggle_present,
	// gate_present, gate_button (1 bit each), zero pad
	input  logic [111:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_mv (16), updated (1), hold_active (1), zero pad
	output logic [23:0]  m_tdata
);
	import shrm_pkg::*;

	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_idx;
	knob_arr_t             knob_q;
	logic                  init_hold_q;

	dp_cmd_t               dp_cmd;
	dp_status_t            dp_st;
	ctrl_status_t          ctrl_st;
	logic [OUT_MV_W-1:0]   dp_out_mv;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;
	logic                  out_free;

	// Register writes
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knob_q[0]   <= 15'sd0;
			knob_q[1]   <= 15'sd10000;
			knob_q[2]   <= 15'sd0;
			knob_q[3]   <= 15'sd10000;
			init_hold_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_KNOB:   knob_q[0]   <= pwdata[MV_W-1:0];
				REG_MAX_KNOB:   knob_q[1]   <= pwdata[MV_W-1:0];
				REG_START_KNOB: knob_q[2]   <= pwdata[MV_W-1:0];
				REG_END_KNOB:   knob_q[3]   <= pwdata[MV_W-1:0];
				REG_INIT_HOLD:  init_hold_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (cfg_idx)
			REG_MIN_KNOB:   prdata = 32'(signed'(knob_q[0]));
			REG_MAX_KNOB:   prdata = 32'(signed'(knob_q[1]));
			REG_START_KNOB: prdata = 32'(signed'(knob_q[2]));
			REG_END_KNOB:   prdata = 32'(signed'(knob_q[3]));
			REG_INIT_HOLD:  prdata = {31'd0, init_hold_q};
			default:        prdata = '0;
		endcase
	end

	assign s_tready = ctrl_st.ready;

	shrm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.out_free     (out_free),
		.cfg_hold_we  (cfg_we && (cfg_idx == REG_INIT_HOLD)),
		.cfg_hold_val (pwdata[0]),
		.dp_st        (dp_st),
		.cmd          (dp_cmd),
		.st           (ctrl_st)
	);

	shrm_dp #(
		.VOLT_BITS (VOLT_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (dp_cmd),
		.in_data (s_tdata),
		.knobs   (knob_q),
		.status  (dp_st),
		.out_mv  (dp_out_mv)
	);

	// Output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_st.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_st.done) begin
			out_data_q <= {6'd0, ctrl_st.hold, ctrl_st.updated, dp_out_mv};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A taken tick keeps the input closed for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a transaction");

	// A finished result only moves when the output register can take it
	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_st.done |-> (!m_tvalid || m_tready))
		else $error("result overwrote a pending output");

	// Writing the hold register loads hold mode at once
	a_hold_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_idx == REG_INIT_HOLD)) |=> (ctrl_st.hold == $past(pwdata[0])))
		else $error("hold mode not loaded by register write");

	// A drained output with nothing new behind it goes empty
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !ctrl_st.done) |=> !m_tvalid)
		else $error("output valid held after drain");

endmodule

// ===== tb/tb_sample_hold_range_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sample_hold_range_mapper_unit
// Self-checking bench for the sample-and-hold range mapper. A queue of ticks
// feeds a stream driver; an in-bench copy of the mapper state predicts every
// output transaction and a monitor compares it field by field. Runs a short
// directed sequence and then random ticks under several knob settings and
// back-pressure mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sample_hold_range_mapper_unit;
	import shrm_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RAND_TICKS    = 300;
	localparam int DRAIN_CYCLES  = 60;
	localparam int MAX_REPORTS   = 10;
	localparam int MV_LIMIT      = 12000;
	localparam int KNOB_LO       = -5000;
	localparam int KNOB_HI       = 10000;
	// Unmapped register slots, writes must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// One input tick, signal in the low bits
	typedef struct packed {
		logic                   gate_button;
		logic                   gate_present;
		logic                   toggle_present;
		logic                   signal_present;
		logic signed [MV_W-1:0] gate_cv;
		logic signed [MV_W-1:0] toggle_cv;
		logic signed [MV_W-1:0] end_cv;
		logic signed [MV_W-1:0] start_cv;
		logic signed [MV_W-1:0] max_cv;
		logic signed [MV_W-1:0] min_cv;
		logic signed [MV_W-1:0] signal;
	} tick_t;

	// One output transaction, out_mv in the low bits
	typedef struct packed {
		logic                       hold_active;
		logic                       updated;
		logic signed [OUT_MV_W-1:0] out_mv;
	} mapped_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [4:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// signal, min_cv, max_cv, start_cv, end_cv, toggle_cv, gate_cv (15 each),
	// signal_present, toggle_present, gate_present, gate_button, zero pad
	logic [111:0] s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// out_mv (16), updated, hold_active, zero pad
	logic [23:0]  m_tdata;

	sample_hold_range_mapper_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mapper state as the bench sees it
	longint                     knob_min   = 0;
	longint                     knob_max   = CV_UNITY;
	longint                     knob_start = 0;
	longint                     knob_end   = CV_UNITY;
	logic                       hold_on    = 1'b0;
	logic                       tog_high   = 1'b1;
	logic                       gate_high  = 1'b1;
	logic signed [OUT_MV_W-1:0] held_mv    = '0;

	tick_t   tick_q[$];
	mapped_t mapped_q[$];
	tick_t   tick_on_bus;
	logic    tick_in_flight = 1'b0;
	int      send_idle_pct  = 0;
	int      recv_idle_pct  = 0;
	int      bad_outs       = 0;
	int      cycle_cnt      = 0;
	int      tog_mv_last    = 0;
	int      gate_mv_last   = 0;

	// Schmitt trigger: returns {new level, rising edge}
	function automatic logic [1:0] schmitt(input logic level,
			input logic signed [MV_W-1:0] mv);
		if (level)
			return {mv > LOW_MV, 1'b0};
		if (mv >= HIGH_MV)
			return 2'b11;
		return 2'b00;
	endfunction

	function automatic longint cv_bound(input longint knob,
			input logic signed [MV_W-1:0] cv);
		longint mag;
		mag = longint'(cv);
		if (mag < 0)
			mag = -mag;
		return (knob * mag) / CV_UNITY;
	endfunction

	// Linear map of the signal from [lo,hi] to [st,en], saturated to 16 bits
	function automatic logic signed [OUT_MV_W-1:0] rescale(input tick_t t);
		longint sig, lo, hi, st, en, r;
		sig = longint'(t.signal);
		lo  = cv_bound(knob_min, t.min_cv);
		hi  = cv_bound(knob_max, t.max_cv);
		st  = cv_bound(knob_start, t.start_cv);
		en  = cv_bound(knob_end, t.end_cv);
		if (hi == lo)
			return '0;
		r = st + ((sig - lo) * (en - st)) / (hi - lo);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return OUT_MV_W'(r);
	endfunction

	// Advance the mapper by one tick and return its output
	function automatic mapped_t step_mapper(input tick_t t);
		logic [1:0] trig;
		logic       refresh;
		refresh = 1'b0;
		if (t.toggle_present) begin
			trig     = schmitt(tog_high, t.toggle_cv);
			tog_high = trig[1];
			if (trig[0])
				hold_on = !hold_on;
		end
		if (t.signal_present) begin
			if (hold_on) begin
				refresh = t.gate_button;
				// gate trigger is skipped while the button is held
				if (!refresh && t.gate_present) begin
					trig      = schmitt(gate_high, t.gate_cv);
					gate_high = trig[1];
					refresh   = trig[0];
				end
			end else begin
				refresh = 1'b1;
			end
			if (refresh)
				held_mv = rescale(t);
		end
		return '{hold_active: hold_on, updated: refresh, out_mv: held_mv};
	endfunction

	function automatic tick_t mk(input int sig, mn, mx, st, en, tog, gate,
			input logic sp, tp, gp, btn);
		tick_t t;
		t.signal         = MV_W'(sig);
		t.min_cv         = MV_W'(mn);
		t.max_cv         = MV_W'(mx);
		t.start_cv       = MV_W'(st);
		t.end_cv         = MV_W'(en);
		t.toggle_cv      = MV_W'(tog);
		t.gate_cv        = MV_W'(gate);
		t.signal_present = sp;
		t.toggle_present = tp;
		t.gate_present   = gp;
		t.gate_button    = btn;
		return t;
	endfunction

	function automatic int rand_mv();
		case ($urandom_range(0, 9))
			0: return -MV_LIMIT;
			1: return MV_LIMIT;
			default: return int'($urandom_range(0, 2 * MV_LIMIT)) - MV_LIMIT;
		endcase
	endfunction

	function automatic int rand_cv();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return CV_UNITY;
			8: return int'($urandom_range(0, 40)) - 20;
			default: return rand_mv();
		endcase
	endfunction

	// Trigger voltages linger so that hold periods last a while
	function automatic int rand_trig(input int last);
		if ($urandom_range(0, 9) < 6)
			return last;
		case ($urandom_range(0, 2))
			0: return int'($urandom_range(0, MV_LIMIT + LOW_MV)) - MV_LIMIT;
			1: return int'($urandom_range(LOW_MV + 1, HIGH_MV - 1));
			default: return int'($urandom_range(HIGH_MV, MV_LIMIT));
		endcase
	endfunction

	function automatic tick_t rand_tick();
		tick_t t;
		int    mn;
		mn           = rand_cv();
		tog_mv_last  = rand_trig(tog_mv_last);
		gate_mv_last = rand_trig(gate_mv_last);
		t = mk(rand_mv(), mn, rand_cv(), rand_cv(), rand_cv(), tog_mv_last,
			gate_mv_last, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
			$urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
		// equal cv on min and max now and then, for equal bounds
		if ($urandom_range(0, 15) == 0)
			t.max_cv = t.min_cv;
		return t;
	endfunction

	function automatic int rand_knob();
		return int'($urandom_range(0, KNOB_HI - KNOB_LO)) + KNOB_LO;
	endfunction

	// APB write: setup, access, register loads at the edge closing access
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MIN_KNOB:   knob_min   = longint'($signed(MV_W'(val)));
			REG_MAX_KNOB:   knob_max   = longint'($signed(MV_W'(val)));
			REG_START_KNOB: knob_start = longint'($signed(MV_W'(val)));
			REG_END_KNOB:   knob_end   = longint'($signed(MV_W'(val)));
			REG_INIT_HOLD:  hold_on    = val[0];
			default: ;
		endcase
	endtask

	task automatic set_knobs(input int mn, mx, st, en, input logic hold);
		reg_write(REG_MIN_KNOB, mn);
		reg_write(REG_MAX_KNOB, mx);
		reg_write(REG_START_KNOB, st);
		reg_write(REG_END_KNOB, en);
		reg_write(REG_INIT_HOLD, int'(hold));
	endtask

	task automatic set_idle_mix(input int mix);
		case (mix)
			0: begin send_idle_pct = 20; recv_idle_pct = 65; end
			1: begin send_idle_pct = 65; recv_idle_pct = 20; end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
		endcase
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || tick_in_flight || mapped_q.size() != 0)
			@(posedge clk);
	endtask

	// Stream driver: predict on acceptance, then present the next tick
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				mapped_q.push_back(step_mapper(tick_on_bus));
				tick_in_flight = 1'b0;
			end
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					tick_on_bus    = tick_q.pop_front();
					tick_in_flight = 1'b1;
					s_tvalid      <= 1'b1;
					s_tdata       <= {3'b000, tick_on_bus};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		mapped_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = mapped_t'(m_tdata[17:0]);
				if (mapped_q.size() == 0) begin
					if (bad_outs < MAX_REPORTS)
						$display("unexpected output transaction: out_mv=%0d upd=%0b hold=%0b",
							got.out_mv, got.updated, got.hold_active);
					bad_outs++;
				end else begin
					want = mapped_q.pop_front();
					if (got.out_mv !== want.out_mv || got.updated !== want.updated ||
							got.hold_active !== want.hold_active) begin
						if (bad_outs < MAX_REPORTS)
							$display("output differs: exp out_mv=%0d upd=%0b hold=%0b, got out_mv=%0d upd=%0b hold=%0b",
								want.out_mv, want.updated, want.hold_active,
								got.out_mv, got.updated, got.hold_active);
						bad_outs++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sample_hold_range_mapper_unit: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under reset knobs: in range equals signal
		set_idle_mix(0);
		// tracking, both extremes
		tick_q.push_back(mk(MV_LIMIT, MV_LIMIT, MV_LIMIT, MV_LIMIT, MV_LIMIT,
			MV_LIMIT, MV_LIMIT, 1, 1, 1, 0));
		tick_q.push_back(mk(-MV_LIMIT, -MV_LIMIT, -MV_LIMIT, -MV_LIMIT, -MV_LIMIT,
			-MV_LIMIT, -MV_LIMIT, 1, 1, 1, 1));
		// toggle edge at the exact high threshold enters hold; gate falls
		tick_q.push_back(mk(5000, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			2000, 0, 1, 1, 1, 0));
		// between thresholds: nothing moves
		tick_q.push_back(mk(1234, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			101, 1999, 1, 1, 1, 0));
		// gate edge at the exact threshold refreshes
		tick_q.push_back(mk(-777, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			101, 2000, 1, 1, 1, 0));
		// both triggers fall at exactly the low threshold
		tick_q.push_back(mk(300, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			100, 100, 1, 1, 1, 0));
		// button refreshes and leaves the gate trigger low
		tick_q.push_back(mk(4321, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			0, 3000, 1, 1, 1, 1));
		// gate jack out: no refresh
		tick_q.push_back(mk(999, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			0, 3000, 1, 1, 0, 0));
		// gate back in: rising edge still pending
		tick_q.push_back(mk(888, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			0, 3000, 1, 1, 1, 0));
		// signal out: toggle still seen, back to tracking, no refresh
		tick_q.push_back(mk(111, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			3000, 0, 0, 1, 1, 0));
		// toggle jack out: level ignored
		tick_q.push_back(mk(-4000, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			-MV_LIMIT, 0, 1, 0, 1, 0));
		// equal bounds
		tick_q.push_back(mk(7000, 5, 0, CV_UNITY, CV_UNITY, 3000, 0, 1, 1, 1, 0));
		// narrow input range saturates both ways
		tick_q.push_back(mk(MV_LIMIT, CV_UNITY, 1, CV_UNITY, -MV_LIMIT,
			3000, 0, 1, 1, 1, 0));
		tick_q.push_back(mk(-MV_LIMIT, CV_UNITY, 1, CV_UNITY, MV_LIMIT,
			3000, 0, 1, 1, 1, 0));
		// negative cvs, toggle falls
		tick_q.push_back(mk(-1, -1, -3, -7, -9999, -MV_LIMIT, -MV_LIMIT, 1, 1, 1, 0));
		// toggle rises while signal is out: hold on, nothing refreshed
		tick_q.push_back(mk(2222, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			MV_LIMIT, MV_LIMIT, 0, 1, 1, 0));
		// hold with gate already high: no edge
		tick_q.push_back(mk(3333, CV_UNITY, CV_UNITY, CV_UNITY, CV_UNITY,
			MV_LIMIT, MV_LIMIT, 1, 1, 1, 0));
		// all jacks out
		tick_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		repeat (RAND_TICKS) tick_q.push_back(rand_tick());
		wait_drained();

		// Random phases over knob extremes and back-pressure mixes
		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: begin
					set_knobs(KNOB_LO, KNOB_HI, KNOB_HI, KNOB_LO, 1'b1);
					reg_write(REG_SPARE_LO, KNOB_HI);
				end
				2: set_knobs(KNOB_HI, KNOB_LO, KNOB_LO, KNOB_HI, 1'b0);
				3: begin
					set_knobs(3000, 3000, rand_knob(), rand_knob(), 1'b1);
					reg_write(REG_SPARE_HI, -1);
				end
				4: set_knobs(rand_knob(), rand_knob(), rand_knob(), rand_knob(), 1'b0);
				default: set_knobs(rand_knob(), rand_knob(), KNOB_LO, KNOB_LO,
					$urandom_range(0, 1));
			endcase
			set_idle_mix(ph / 2);
			repeat (RAND_TICKS) tick_q.push_back(rand_tick());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_outs == 0)
			$display("sample_hold_range_mapper_unit: match");
		else
			$display("sample_hold_range_mapper_unit: mismatch");
		$finish;
	end

endmodule
